FILE: hdl/vwap_window_crossover_signal_macros.svh
// Assertion macros for the VWAP crossover block.
// Included by the top level; no other dependencies.
`ifndef VWAP_WINDOW_CROSSOVER_SIGNAL_MACROS_SVH
`define VWAP_WINDOW_CROSSOVER_SIGNAL_MACROS_SVH
`define VWCS_ASSERT_IMPL(lbl, a, c, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |-> (c)) else $error(msg);
`define VWCS_ASSERT_NEXT(lbl, a, c, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (a) |=> (c)) else $error(msg);
`endif

FILE: hdl/vwcs_pkg.sv
// Shared types and constants for the VWAP crossover block.
// No dependencies.
package vwcs_pkg;
    localparam int HISTORY_DEPTH_DEF = 1024;
    localparam int FRACTION_BITS_DEF = 16;
    localparam logic [15:0] SHORT_WINDOW_RST = 16'd360;
    localparam logic [15:0] LONG_WINDOW_RST = 16'd600;
    localparam logic [0:0] REG_SHORT = 1'b0;
    localparam logic [0:0] REG_LONG = 1'b1;
    localparam logic [1:0] SIG_NONE = 2'd0;
    localparam logic [1:0] SIG_BUY = 2'd1;
    localparam logic [1:0] SIG_SELL = 2'd2;
    localparam logic [47:0] MASK48 = 48'hFFFF_FFFF_FFFF;

    typedef struct packed {
        logic [31:0] ts;
        logic [47:0] turnover;
        logic [31:0] volume;
        logic [31:0] price;
    } tick_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_SRD, ST_SCHK, ST_LRD, ST_LCHK, ST_DIV, ST_FULLRD, ST_FULLDO,
        ST_PUSH, ST_OUT
    } state_t;
endpackage

FILE: hdl/vwcs_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module vwcs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: hdl/vwcs_front.sv
// Front end: input acceptance into a two-entry tick queue.
// Depends on vwcs_pkg.
module vwcs_front (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  vwcs_pkg::tick_t  in_tick,
    output logic             q_valid,
    input  logic             q_pop,
    output vwcs_pkg::tick_t  q_tick
);
    vwcs_pkg::tick_t mem_reg [2];
    logic rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    logic push;

    assign in_ready = (cnt_reg != 2'd2);
    assign push = in_valid && in_ready;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_tick = mem_reg[rd_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_reg <= 1'b0;
            wr_reg <= 1'b0;
            cnt_reg <= 2'd0;
        end else begin
            if (push) begin
                wr_reg <= ~wr_reg;
            end
            if (q_pop && q_valid) begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, q_pop && q_valid};
        end
        if (push) begin
            mem_reg[wr_reg] <= in_tick;
        end
    end
endmodule

FILE: hdl/vwcs_div.sv
// Bit-serial fixed-point divider, one quotient bit per cycle, saturating.
// Depends on vwcs_pkg.
module vwcs_div #(
    parameter int FRACTION_BITS = vwcs_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [64:0] num,
    input  logic [47:0] den,
    output logic        busy,
    output logic [47:0] quo
);
    localparam int STEPS = 65 + FRACTION_BITS;
    localparam int CW = $clog2(STEPS + 1);
    logic [64:0] sh_reg;
    logic [48:0] r_reg;
    logic [47:0] q_reg, den_reg;
    logic sat_reg;
    logic [CW-1:0] k_reg;
    logic [48:0] rs;

    assign busy = (k_reg != '0);
    assign quo = sat_reg ? vwcs_pkg::MASK48 : q_reg;
    assign rs = {r_reg[47:0], sh_reg[64]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= '0;
        end else if (start) begin
            k_reg <= CW'(STEPS);
        end else if (busy) begin
            k_reg <= k_reg - 1'b1;
        end
        if (start) begin
            sh_reg <= num;
            r_reg <= '0;
            q_reg <= '0;
            sat_reg <= 1'b0;
            den_reg <= den;
        end else if (busy) begin
            sh_reg <= {sh_reg[63:0], 1'b0};
            if (q_reg[47]) begin
                sat_reg <= 1'b1;
            end
            if (rs >= {1'b0, den_reg}) begin
                r_reg <= rs - {1'b0, den_reg};
                q_reg <= {q_reg[46:0], 1'b1};
            end else begin
                r_reg <= rs;
                q_reg <= {q_reg[46:0], 1'b0};
            end
        end
    end
endmodule

FILE: hdl/vwcs_back.sv
// Back end: window eviction, averages, crossover decision, history ring.
// Depends on vwcs_pkg, vwcs_ram, vwcs_div.
module vwcs_back #(
    parameter int HISTORY_DEPTH = vwcs_pkg::HISTORY_DEPTH_DEF,
    parameter int FRACTION_BITS = vwcs_pkg::FRACTION_BITS_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic [15:0]      short_window,
    input  logic [15:0]      long_window,
    input  logic             q_valid,
    output logic             q_pop,
    input  vwcs_pkg::tick_t  q_tick,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [1:0]       m_signal,
    output logic [31:0]      m_order_price,
    output logic [47:0]      m_short_average,
    output logic [47:0]      m_long_average,
    output logic             m_zero_volume,
    output logic             busy
);
    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int LW = AW + 1;
    localparam logic [LW-1:0] DEPTH_L = LW'(HISTORY_DEPTH);
    localparam int HW = 112;

    vwcs_pkg::state_t st_reg, st_next;
    vwcs_pkg::tick_t t_reg;
    logic [AW-1:0] head_reg, stail_reg, ltail_reg, raddr;
    logic [LW-1:0] hcnt_reg, slen_reg, llen_reg;
    logic [63:0] sts_reg, lts_reg;
    logic [47:0] svs_reg, lvs_reg, savg_reg, lavg_reg, pavs_reg, pavl_reg;
    logic pv_reg, dlong_reg, dst_reg;
    logic [HW-1:0] rdata;
    logic [31:0] r_ts;
    logic [47:0] r_to;
    logic [31:0] r_vo;
    logic [64:0] snum, lnum;
    logic [47:0] sden, lden;
    logic szero, lzero, zero, div_start, div_busy, div_long;
    logic [47:0] div_quo;
    logic [1:0] sig;

    assign r_ts = rdata[111:80];
    assign r_to = rdata[79:32];
    assign r_vo = rdata[31:0];

    vwcs_ram #(.WIDTH(HW), .DEPTH(HISTORY_DEPTH)) u_hist (
        .aclk(aclk), .we(st_reg == vwcs_pkg::ST_PUSH), .waddr(head_reg),
        .wdata({t_reg.ts, t_reg.turnover, t_reg.volume}), .raddr(raddr), .rdata(rdata)
    );

    assign snum = {1'b0, sts_reg} + {17'd0, t_reg.turnover};
    assign lnum = {1'b0, lts_reg} + {17'd0, t_reg.turnover};
    assign sden = svs_reg + {16'd0, t_reg.volume};
    assign lden = lvs_reg + {16'd0, t_reg.volume};
    assign szero = (sden == '0);
    assign lzero = (lden == '0);
    assign zero = szero || lzero;
    assign div_long = (st_reg == vwcs_pkg::ST_DIV);

    vwcs_div #(.FRACTION_BITS(FRACTION_BITS)) u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start),
        .num(div_long ? lnum : snum), .den(div_long ? lden : sden),
        .busy(div_busy), .quo(div_quo)
    );

    always_comb begin
        sig = vwcs_pkg::SIG_NONE;
        if (pv_reg && !zero) begin
            if (pavl_reg > pavs_reg) begin
                if (savg_reg > lavg_reg) begin
                    sig = vwcs_pkg::SIG_BUY;
                end
            end else if (savg_reg < lavg_reg) begin
                sig = vwcs_pkg::SIG_SELL;
            end
        end
    end

    assign busy = (st_reg != vwcs_pkg::ST_IDLE) || q_valid;
    assign m_valid = (st_reg == vwcs_pkg::ST_OUT);

    always_comb begin
        st_next = st_reg;
        q_pop = 1'b0;
        div_start = 1'b0;
        raddr = stail_reg;
        case (st_reg)
            vwcs_pkg::ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    st_next = vwcs_pkg::ST_SRD;
                end
            end
            vwcs_pkg::ST_SRD: st_next = vwcs_pkg::ST_SCHK;
            vwcs_pkg::ST_SCHK: begin
                if (slen_reg != '0 &&
                    {1'b0, r_ts} + {17'd0, short_window} <= {1'b0, t_reg.ts}) begin
                    st_next = vwcs_pkg::ST_SRD;
                end else begin
                    st_next = vwcs_pkg::ST_LRD;
                end
            end
            vwcs_pkg::ST_LRD: begin
                raddr = ltail_reg;
                st_next = vwcs_pkg::ST_LCHK;
            end
            vwcs_pkg::ST_LCHK: begin
                raddr = ltail_reg;
                if (llen_reg != '0 &&
                    {1'b0, r_ts} + {17'd0, long_window} <= {1'b0, t_reg.ts}) begin
                    st_next = vwcs_pkg::ST_LRD;
                end else begin
                    div_start = 1'b1;
                    st_next = vwcs_pkg::ST_DIV;
                end
            end
            vwcs_pkg::ST_DIV: begin
                if (!div_busy && !dst_reg) begin
                    if (!dlong_reg) begin
                        div_start = 1'b1;
                    end else begin
                        st_next = vwcs_pkg::ST_FULLRD;
                    end
                end
            end
            vwcs_pkg::ST_FULLRD: begin
                raddr = stail_reg;
                st_next = vwcs_pkg::ST_FULLDO;
            end
            vwcs_pkg::ST_FULLDO: begin
                raddr = ltail_reg;
                st_next = vwcs_pkg::ST_PUSH;
            end
            vwcs_pkg::ST_PUSH: st_next = vwcs_pkg::ST_OUT;
            vwcs_pkg::ST_OUT: begin
                if (m_ready) begin
                    st_next = vwcs_pkg::ST_IDLE;
                end
            end
            default: st_next = vwcs_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= vwcs_pkg::ST_IDLE;
            head_reg <= '0;
            hcnt_reg <= '0;
            stail_reg <= '0;
            ltail_reg <= '0;
            slen_reg <= '0;
            llen_reg <= '0;
            sts_reg <= '0;
            lts_reg <= '0;
            svs_reg <= '0;
            lvs_reg <= '0;
            pavs_reg <= '0;
            pavl_reg <= '0;
            pv_reg <= 1'b0;
            dlong_reg <= 1'b0;
            dst_reg <= 1'b0;
        end else begin
            st_reg <= st_next;
            dst_reg <= div_start;
            if (q_pop) begin
                t_reg <= q_tick;
                dlong_reg <= 1'b0;
            end
            if (st_reg == vwcs_pkg::ST_SCHK && st_next == vwcs_pkg::ST_SRD) begin
                sts_reg <= sts_reg - {16'd0, r_to};
                svs_reg <= svs_reg - {16'd0, r_vo};
                stail_reg <= (stail_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : stail_reg + 1'b1;
                slen_reg <= slen_reg - 1'b1;
            end
            if (st_reg == vwcs_pkg::ST_LCHK && st_next == vwcs_pkg::ST_LRD) begin
                lts_reg <= lts_reg - {16'd0, r_to};
                lvs_reg <= lvs_reg - {16'd0, r_vo};
                ltail_reg <= (ltail_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : ltail_reg + 1'b1;
                llen_reg <= llen_reg - 1'b1;
            end
            if (st_reg == vwcs_pkg::ST_DIV && !div_busy && !dst_reg) begin
                if (!dlong_reg) begin
                    savg_reg <= szero ? '0 : div_quo;
                    dlong_reg <= 1'b1;
                end else begin
                    lavg_reg <= lzero ? '0 : div_quo;
                end
            end
            if (st_reg == vwcs_pkg::ST_FULLRD) begin
                m_signal <= sig;
                m_order_price <= (sig != vwcs_pkg::SIG_NONE) ? t_reg.price : '0;
                m_short_average <= savg_reg;
                m_long_average <= lavg_reg;
                m_zero_volume <= zero;
                pavs_reg <= savg_reg;
                pavl_reg <= lavg_reg;
                pv_reg <= !zero;
            end
            if (st_reg == vwcs_pkg::ST_FULLDO) begin
                if (hcnt_reg >= DEPTH_L && slen_reg >= DEPTH_L) begin
                    sts_reg <= sts_reg - {16'd0, r_to} + {16'd0, t_reg.turnover};
                    svs_reg <= svs_reg - {16'd0, r_vo} + {16'd0, t_reg.volume};
                    stail_reg <= (stail_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : stail_reg + 1'b1;
                end else begin
                    sts_reg <= sts_reg + {16'd0, t_reg.turnover};
                    svs_reg <= svs_reg + {16'd0, t_reg.volume};
                    slen_reg <= slen_reg + 1'b1;
                    if (slen_reg == '0) begin
                        stail_reg <= head_reg;
                    end
                end
            end
            if (st_reg == vwcs_pkg::ST_PUSH) begin
                if (hcnt_reg >= DEPTH_L && llen_reg >= DEPTH_L) begin
                    lts_reg <= lts_reg - {16'd0, r_to} + {16'd0, t_reg.turnover};
                    lvs_reg <= lvs_reg - {16'd0, r_vo} + {16'd0, t_reg.volume};
                    ltail_reg <= (ltail_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : ltail_reg + 1'b1;
                end else begin
                    lts_reg <= lts_reg + {16'd0, t_reg.turnover};
                    lvs_reg <= lvs_reg + {16'd0, t_reg.volume};
                    llen_reg <= llen_reg + 1'b1;
                    if (llen_reg == '0) begin
                        ltail_reg <= head_reg;
                    end
                end
                if (hcnt_reg < DEPTH_L) begin
                    hcnt_reg <= hcnt_reg + 1'b1;
                end
                head_reg <= (head_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            end
        end
    end
endmodule

FILE: hdl/vwap_window_crossover_signal.sv
// Top level of the VWAP crossover block: config registers, front queue, back end.
// Depends on vwcs_pkg, vwcs_front, vwcs_back and the assertion macro header.
//
//   channel | direction | handshake
//   s_      | in        | s_valid / s_ready
//   m_      | out       | m_valid / m_ready
//   apb     | in        | psel / penable / pwrite, pready tied high
//
// The processing time of an item is set by the two serial divisions and the
// one-read-per-cycle history RAM; it grows with every tick evicted from either
// window, each passing a read and a check state, and with any wait on m_ready.
// Reset is synchronous on aresetn; the history RAM needs no clearing pass.
// A two-entry queue takes up to two more transfers while the back end stalls.
`include "vwap_window_crossover_signal_macros.svh"
module vwap_window_crossover_signal #(
    parameter int HISTORY_DEPTH = vwcs_pkg::HISTORY_DEPTH_DEF,
    parameter int FRACTION_BITS = vwcs_pkg::FRACTION_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_tick_timestamp,
    input  logic [47:0] s_turnover,
    input  logic [31:0] s_volume,
    input  logic [31:0] s_last_price,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_signal,
    output logic [31:0] m_order_price,
    output logic [47:0] m_short_average,
    output logic [47:0] m_long_average,
    output logic        m_zero_volume
);
    logic [15:0] swin_reg, lwin_reg;
    logic q_valid, q_pop, busy;
    vwcs_pkg::tick_t in_tick, q_tick;
    logic wr;

    assign pready = 1'b1;
    assign wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == vwcs_pkg::REG_SHORT && paddr[1:0] == 2'd0) ?
                    {16'd0, swin_reg} : (paddr[1:0] == 2'd0) ? {16'd0, lwin_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            swin_reg <= vwcs_pkg::SHORT_WINDOW_RST;
            lwin_reg <= vwcs_pkg::LONG_WINDOW_RST;
        end else if (wr && paddr[1:0] == 2'd0) begin
            if (paddr[2] == vwcs_pkg::REG_SHORT) begin
                swin_reg <= pwdata[15:0];
            end
            if (paddr[2] == vwcs_pkg::REG_LONG) begin
                lwin_reg <= pwdata[15:0];
            end
        end
    end

    assign in_tick = '{ts: s_tick_timestamp, turnover: s_turnover,
                       volume: s_volume, price: s_last_price};

    vwcs_front u_front (
        .aclk(aclk), .aresetn(aresetn), .in_valid(s_valid), .in_ready(s_ready),
        .in_tick(in_tick), .q_valid(q_valid), .q_pop(q_pop), .q_tick(q_tick)
    );

    vwcs_back #(.HISTORY_DEPTH(HISTORY_DEPTH), .FRACTION_BITS(FRACTION_BITS)) u_back (
        .aclk(aclk), .aresetn(aresetn), .short_window(swin_reg), .long_window(lwin_reg),
        .q_valid(q_valid), .q_pop(q_pop), .q_tick(q_tick),
        .m_valid(m_valid), .m_ready(m_ready), .m_signal(m_signal),
        .m_order_price(m_order_price), .m_short_average(m_short_average),
        .m_long_average(m_long_average), .m_zero_volume(m_zero_volume), .busy(busy)
    );

    `VWCS_ASSERT_IMPL(a_sig_code, m_valid, m_signal != 2'd3, "invalid signal code")
    `VWCS_ASSERT_IMPL(a_zero_nosig, m_valid && m_zero_volume,
        m_signal == vwcs_pkg::SIG_NONE, "signal on zero volume")
    `VWCS_ASSERT_IMPL(a_price, m_valid && m_signal == vwcs_pkg::SIG_NONE,
        m_order_price == 32'd0, "price without signal")
    `VWCS_ASSERT_IMPL(a_out_busy, m_valid, busy, "output without busy back end")
endmodule
